### rtl/smrt_pkg.sv
// Shared constants, codes and types for the sorted memory region table.
package smrt_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    localparam logic [63:0] LOW_MEMORY_LIMIT = 64'h0000_0000_0010_0000;
    localparam logic [31:0] USABLE_TYPE = 32'd1;

    localparam logic [1:0] OP_MAP_ENTRY = 2'd0;
    localparam logic [1:0] OP_RAW_INSERT = 2'd1;
    localparam logic [1:0] OP_FIND = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_SKIPPED = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;

    localparam logic [1:0] KIND_SKIP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_FIND = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] addr;
        logic [63:0] len;
        logic [3:0]  idx;
    } cmd_t;

endpackage

### rtl/smrt_front.sv
// Front end: accepts input beats, filters and normalises map entries, builds commands.
module smrt_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [31:0]        s_entry_type,
    input  logic [63:0]        s_base_address,
    input  logic [63:0]        s_region_size,
    input  logic [63:0]        s_lookup_address,
    input  logic [3:0]         s_entry_index,
    input  logic               q_full,
    output logic               q_push,
    output smrt_pkg::cmd_t     q_cmd
);
    import smrt_pkg::*;

    logic [64:0] map_end;
    logic        map_carry;
    logic        map_skip;

    assign s_ready = !q_full;
    assign q_push = s_valid && !q_full;

    assign map_end = {1'b0, s_base_address} + {1'b0, s_region_size};
    assign map_carry = map_end[64];
    assign map_skip = (s_entry_type != USABLE_TYPE) ||
                      (!map_carry && (map_end[63:0] <= LOW_MEMORY_LIMIT));

    always_comb begin
        q_cmd.kind = KIND_INSERT;
        q_cmd.addr = s_base_address;
        q_cmd.len = s_region_size;
        q_cmd.idx = s_entry_index;
        case (s_opcode)
            OP_MAP_ENTRY: begin
                if (map_skip) begin
                    q_cmd.kind = KIND_SKIP;
                end else if (s_base_address <= LOW_MEMORY_LIMIT) begin
                    q_cmd.addr = 64'd0;
                    q_cmd.len = map_carry ? {64{1'b1}} : map_end[63:0];
                end
            end
            OP_RAW_INSERT: begin
                q_cmd.kind = KIND_INSERT;
            end
            OP_FIND: begin
                q_cmd.kind = KIND_FIND;
                q_cmd.addr = s_lookup_address;
            end
            OP_READ: begin
                q_cmd.kind = KIND_READ;
            end
            default: begin
                q_cmd.kind = KIND_SKIP;
            end
        endcase
    end

endmodule

### rtl/smrt_queue.sv
// Two-entry command queue between the front end and the table engine.
module smrt_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  smrt_pkg::cmd_t     push_cmd,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output smrt_pkg::cmd_t     head_cmd
);
    import smrt_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_push;
    logic       do_pop;

    assign full = (fill_reg == 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/smrt_back.sv
// Table engine: region memory, insertion shift, address scan, index read and result register.
module smrt_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  smrt_pkg::cmd_t     q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [3:0]         m_found_index,
    output logic [63:0]        m_found_start,
    output logic [63:0]        m_found_length,
    output logic               m_has_next,
    output logic [4:0]         m_region_total
);
    import smrt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS = 3'd1;
    localparam logic [2:0] S_PUT = 3'd2;
    localparam logic [2:0] S_FIND = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;

    logic [63:0] start_mem [MAX_REGIONS];
    logic [63:0] len_mem [MAX_REGIONS];

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [63:0]      rd_start_reg;
    logic [63:0]      rd_len_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [2:0]       status_reg;
    logic [3:0]       index_reg;
    logic [63:0]      start_reg;
    logic [63:0]      length_reg;
    logic             has_next_reg;
    logic [4:0]       total_reg;

    logic             out_free;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [63:0]      wr_start;
    logic [63:0]      wr_len;

    logic             res_load;
    logic [2:0]       res_status;
    logic [IDX_W-1:0] res_index;
    logic [63:0]      res_start;
    logic [63:0]      res_length;
    logic             res_has_next;
    logic [CNT_W-1:0] res_total;

    logic [CNT_W-1:0] k_wide;
    logic [CNT_W-1:0] k_plus_one;
    logic [CNT_W-1:0] count_minus_one;
    logic [63:0]      addr_offset;
    logic             hit;

    assign out_free = !out_valid_reg || m_ready;
    assign k_wide = CNT_W'(k_reg);
    assign k_plus_one = k_wide + CNT_W'(1);
    assign count_minus_one = count_reg - CNT_W'(1);
    assign addr_offset = cmd_reg.addr - rd_start_reg;
    assign hit = (cmd_reg.addr >= rd_start_reg) && (addr_offset < rd_len_reg);

    always_comb begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        k_next = k_reg;
        count_next = count_reg;
        q_pop = 1'b0;
        rd_addr = k_reg;
        wr_en = 1'b0;
        wr_addr = k_reg;
        wr_start = cmd_reg.addr;
        wr_len = cmd_reg.len;
        res_load = 1'b0;
        res_status = ST_OK;
        res_index = '0;
        res_start = 64'd0;
        res_length = 64'd0;
        res_has_next = 1'b0;
        res_total = count_reg;
        case (state_reg)
            S_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    cmd_next = q_cmd;
                    case (q_cmd.kind)
                        KIND_SKIP: begin
                            res_load = 1'b1;
                            res_status = ST_SKIPPED;
                        end
                        KIND_INSERT: begin
                            if (count_reg == CNT_W'(MAX_REGIONS)) begin
                                res_load = 1'b1;
                                res_status = ST_FULL;
                            end else if (count_reg == '0) begin
                                wr_en = 1'b1;
                                wr_addr = '0;
                                wr_start = q_cmd.addr;
                                wr_len = q_cmd.len;
                                count_next = CNT_W'(1);
                                res_load = 1'b1;
                                res_start = q_cmd.addr;
                                res_length = q_cmd.len;
                                res_total = CNT_W'(1);
                            end else begin
                                k_next = count_minus_one[IDX_W-1:0];
                                rd_addr = count_minus_one[IDX_W-1:0];
                                state_next = S_INS;
                            end
                        end
                        KIND_FIND: begin
                            if (count_reg == '0) begin
                                res_load = 1'b1;
                                res_status = ST_NOT_FOUND;
                            end else begin
                                k_next = '0;
                                rd_addr = '0;
                                state_next = S_FIND;
                            end
                        end
                        KIND_READ: begin
                            if (CNT_W'(q_cmd.idx) >= count_reg) begin
                                res_load = 1'b1;
                                res_status = ST_BAD_INDEX;
                            end else begin
                                k_next = IDX_W'(q_cmd.idx);
                                rd_addr = IDX_W'(q_cmd.idx);
                                state_next = S_READ;
                            end
                        end
                        default: begin
                            res_load = 1'b1;
                            res_status = ST_SKIPPED;
                        end
                    endcase
                end
            end
            S_INS: begin
                wr_en = 1'b1;
                wr_addr = k_plus_one[IDX_W-1:0];
                if (rd_start_reg > cmd_reg.addr) begin
                    wr_start = rd_start_reg;
                    wr_len = rd_len_reg;
                    if (k_reg == '0) begin
                        state_next = S_PUT;
                    end else begin
                        k_next = k_reg - IDX_W'(1);
                        rd_addr = k_reg - IDX_W'(1);
                    end
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    res_load = 1'b1;
                    res_index = k_plus_one[IDX_W-1:0];
                    res_start = cmd_reg.addr;
                    res_length = cmd_reg.len;
                    res_has_next = (k_plus_one < count_reg);
                    res_total = count_reg + CNT_W'(1);
                    state_next = S_IDLE;
                end
            end
            S_PUT: begin
                wr_en = 1'b1;
                wr_addr = '0;
                count_next = count_reg + CNT_W'(1);
                res_load = 1'b1;
                res_start = cmd_reg.addr;
                res_length = cmd_reg.len;
                res_has_next = (count_reg != '0);
                res_total = count_reg + CNT_W'(1);
                state_next = S_IDLE;
            end
            S_FIND: begin
                if (hit) begin
                    res_load = 1'b1;
                    res_index = k_reg;
                    res_start = rd_start_reg;
                    res_length = rd_len_reg;
                    res_has_next = (k_plus_one < count_reg);
                    state_next = S_IDLE;
                end else if (k_plus_one == count_reg) begin
                    res_load = 1'b1;
                    res_status = ST_NOT_FOUND;
                    state_next = S_IDLE;
                end else begin
                    k_next = k_plus_one[IDX_W-1:0];
                    rd_addr = k_plus_one[IDX_W-1:0];
                end
            end
            S_READ: begin
                res_load = 1'b1;
                res_index = k_reg;
                res_start = rd_start_reg;
                res_length = rd_len_reg;
                res_has_next = (k_plus_one < count_reg);
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        k_reg <= k_next;
        if (res_load) begin
            status_reg <= res_status;
            index_reg <= 4'(res_index);
            start_reg <= res_start;
            length_reg <= res_length;
            has_next_reg <= res_has_next;
            total_reg <= 5'(res_total);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            start_mem[wr_addr] <= wr_start;
            len_mem[wr_addr] <= wr_len;
        end
        rd_start_reg <= start_mem[rd_addr];
        rd_len_reg <= len_mem[rd_addr];
    end

    assign m_valid = out_valid_reg;
    assign m_status = status_reg;
    assign m_found_index = index_reg;
    assign m_found_start = start_reg;
    assign m_found_length = length_reg;
    assign m_has_next = has_next_reg;
    assign m_region_total = total_reg;

endmodule

### rtl/sorted_memory_region_table.sv
// Top level of the sorted memory region table: front end, command queue and table engine.
//
// Holds up to 16 memory regions sorted by start address in a region memory with one
// write port and registered reads. Beats are filtered by the front end and wait in a
// two-entry queue, so input is taken while the engine works, until the queue is full.
// A skipped map entry, a full-table insert, an insert into an empty table, an
// out-of-range read or a lookup in an empty table is answered straight from idle; a
// read by index first reads the region memory; an insert into a filled table runs the
// one-entry-per-cycle shift walk from the top down to the insertion slot; a lookup
// runs the one-entry-per-cycle scan from index 0 up. The memory needs no clearing pass.
module sorted_memory_region_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_entry_type,
    input  logic [63:0] s_base_address,
    input  logic [63:0] s_region_size,
    input  logic [63:0] s_lookup_address,
    input  logic [3:0]  s_entry_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_found_index,
    output logic [63:0] m_found_start,
    output logic [63:0] m_found_length,
    output logic        m_has_next,
    output logic [4:0]  m_region_total
);
    import smrt_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t q_head_cmd;

    smrt_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_entry_type     (s_entry_type),
        .s_base_address   (s_base_address),
        .s_region_size    (s_region_size),
        .s_lookup_address (s_lookup_address),
        .s_entry_index    (s_entry_index),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_cmd            (q_push_cmd)
    );

    smrt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head_cmd)
    );

    smrt_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_cmd          (q_head_cmd),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_found_index  (m_found_index),
        .m_found_start  (m_found_start),
        .m_found_length (m_found_length),
        .m_has_next     (m_has_next),
        .m_region_total (m_region_total)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_memory_region_table against a local table model.
module tb_top;
    import smrt_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  index;
        logic [63:0] start;
        logic [63:0] length;
        logic        has_next;
        logic [4:0]  total;
    } region_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [31:0] s_entry_type;
    logic [63:0] s_base_address;
    logic [63:0] s_region_size;
    logic [63:0] s_lookup_address;
    logic [3:0]  s_entry_index;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [3:0]  m_found_index;
    logic [63:0] m_found_start;
    logic [63:0] m_found_length;
    logic        m_has_next;
    logic [4:0]  m_region_total;

    logic [63:0]   region_starts [MAX_REGIONS];
    logic [63:0]   region_lengths [MAX_REGIONS];
    int            region_count = 0;
    region_reply_t region_replies_due [$];
    int            reply_errors = 0;
    bit            src_idle = 1'b0;
    bit            dst_idle = 1'b0;
    int            hold_len = 0;

    sorted_memory_region_table u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_entry_type     (s_entry_type),
        .s_base_address   (s_base_address),
        .s_region_size    (s_region_size),
        .s_lookup_address (s_lookup_address),
        .s_entry_index    (s_entry_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_index    (m_found_index),
        .m_found_start    (m_found_start),
        .m_found_length   (m_found_length),
        .m_has_next       (m_has_next),
        .m_region_total   (m_region_total)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] rand_u64();
        return {$urandom, $urandom};
    endfunction

    function automatic int idle_cycles(bit enabled);
        if (!enabled || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [63:0] pick_addr();
        case ($urandom_range(0, 6))
            0: return rand_u64();
            1: return 64'($urandom_range(0, 32'h0020_0000));
            2: return LOW_MEMORY_LIMIT + 64'($urandom_range(0, 2)) - 64'd1;
            3: return '1 - 64'($urandom_range(0, 32'h0000_FFFF));
            4: return (region_count > 0) ?
                   region_starts[$urandom_range(0, region_count - 1)] : rand_u64();
            5: return {$urandom, 32'h0};
            default: return 64'($urandom) << $urandom_range(0, 32);
        endcase
    endfunction

    task automatic apply_region_op(input logic [1:0] op, input logic [31:0] etype,
                                   input logic [63:0] base, input logic [63:0] size,
                                   input logic [63:0] addr, input logic [3:0] idx);
        region_reply_t r;
        logic [64:0]   end_sum;
        logic [63:0]   st;
        logic [63:0]   len;
        int            pos;
        int            k;
        bit            hit;
        r = '0;
        st = base;
        len = size;
        case (op)
            OP_MAP_ENTRY, OP_RAW_INSERT: begin
                end_sum = {1'b0, base} + {1'b0, size};
                if (op == OP_MAP_ENTRY && (etype != USABLE_TYPE ||
                        (!end_sum[64] && end_sum[63:0] <= LOW_MEMORY_LIMIT))) begin
                    r.status = ST_SKIPPED;
                end else begin
                    if (op == OP_MAP_ENTRY && base <= LOW_MEMORY_LIMIT) begin
                        st = '0;
                        len = end_sum[64] ? '1 : end_sum[63:0];
                    end
                    if (region_count >= MAX_REGIONS) begin
                        r.status = ST_FULL;
                    end else begin
                        pos = region_count;
                        for (k = region_count - 1; k >= 0; k--) begin
                            if (region_starts[k] > st) pos = k;
                        end
                        for (k = region_count; k > pos; k--) begin
                            region_starts[k] = region_starts[k - 1];
                            region_lengths[k] = region_lengths[k - 1];
                        end
                        region_starts[pos] = st;
                        region_lengths[pos] = len;
                        region_count++;
                        r.status = ST_OK;
                        r.index = 4'(pos);
                        r.start = st;
                        r.length = len;
                        r.has_next = (pos + 1 < region_count);
                    end
                end
            end
            OP_FIND: begin
                hit = 1'b0;
                for (k = 0; k < region_count; k++) begin
                    if (!hit && addr >= region_starts[k] &&
                            addr - region_starts[k] < region_lengths[k]) begin
                        hit = 1'b1;
                        r.status = ST_OK;
                        r.index = 4'(k);
                        r.start = region_starts[k];
                        r.length = region_lengths[k];
                        r.has_next = (k + 1 < region_count);
                    end
                end
                if (!hit) r.status = ST_NOT_FOUND;
            end
            OP_READ: begin
                if (int'(idx) >= region_count) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    r.status = ST_OK;
                    r.index = idx;
                    r.start = region_starts[idx];
                    r.length = region_lengths[idx];
                    r.has_next = (int'(idx) + 1 < region_count);
                end
            end
            default: begin
                r.status = ST_SKIPPED;
            end
        endcase
        r.total = 5'(region_count);
        region_replies_due.push_back(r);
    endtask

    task automatic send_beat(input logic [1:0] op, input logic [31:0] etype,
                             input logic [63:0] base, input logic [63:0] size,
                             input logic [63:0] addr, input logic [3:0] idx);
        int gap;
        gap = idle_cycles(src_idle);
        @(negedge aclk);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_entry_type <= etype;
        s_base_address <= base;
        s_region_size <= size;
        s_lookup_address <= addr;
        s_entry_index <= idx;
        do @(posedge aclk); while (!s_ready);
        apply_region_op(op, etype, base, size, addr, idx);
    endtask

    task automatic wait_replies_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (region_replies_due.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random_beat();
        logic [1:0]  op;
        logic [31:0] etype;
        logic [63:0] base;
        logic [63:0] size;
        logic [63:0] addr;
        logic [63:0] st;
        logic [63:0] len;
        logic [3:0]  idx;
        int          pick;
        int          ins_pct;
        op = OP_READ;
        etype = $urandom;
        base = rand_u64();
        size = rand_u64();
        addr = rand_u64();
        idx = 4'($urandom);
        ins_pct = (region_count < MAX_REGIONS) ? 10 : 15;
        pick = $urandom_range(0, 99);
        if (pick < ins_pct) begin
            op = ($urandom_range(0, 9) < 7) ? OP_MAP_ENTRY : OP_RAW_INSERT;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                etype = USABLE_TYPE;
            end else if (pick < 8) begin
                etype = 32'($urandom_range(0, 4));
            end
            base = pick_addr();
            case ($urandom_range(0, 5))
                0: size = '0;
                1: size = 64'($urandom_range(1, 4096));
                2: size = rand_u64();
                3: size = '1;
                4: size = {32'h0, $urandom};
                default: size = 64'($urandom_range(0, 32'h0020_0000));
            endcase
        end else if (pick < ins_pct + 55) begin
            op = OP_FIND;
            if (region_count > 0 && $urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, region_count - 1);
                st = region_starts[pick];
                len = region_lengths[pick];
                case ($urandom_range(0, 4))
                    0: addr = st;
                    1: addr = st + len - 64'd1;
                    2: addr = st + len;
                    3: addr = st - 64'd1;
                    default: addr = (len != 0) ? st + rand_u64() % len : st;
                endcase
            end else begin
                addr = pick_addr();
            end
        end
        send_beat(op, etype, base, size, addr, idx);
    endtask

    task automatic test_empty_table();
        send_beat(OP_FIND, 32'd0, 64'd0, 64'd0, 64'd0, 4'd0);
        send_beat(OP_READ, 32'd0, 64'd0, 64'd0, 64'd0, 4'd0);
        send_beat(OP_READ, 32'd0, 64'd0, 64'd0, 64'd0, 4'd15);
        send_beat(OP_MAP_ENTRY, 32'd0, 64'h20_0000, 64'h1000, 64'd0, 4'd0);
        send_beat(OP_MAP_ENTRY, 32'hFFFF_FFFF, 64'h20_0000, 64'h1000, 64'd0, 4'd0);
        send_beat(OP_MAP_ENTRY, 32'd2, 64'h20_0000, 64'h1000, 64'd0, 4'd0);
        send_beat(OP_MAP_ENTRY, USABLE_TYPE, 64'd0, LOW_MEMORY_LIMIT, 64'd0, 4'd0);
        send_beat(OP_MAP_ENTRY, USABLE_TYPE, 64'h8_0000, 64'h8_0000, 64'd0, 4'd0);
        send_beat(OP_MAP_ENTRY, USABLE_TYPE, 64'd0, 64'd0, 64'd0, 4'd0);
    endtask

    task automatic test_map_filter();
        send_beat(OP_MAP_ENTRY, USABLE_TYPE, LOW_MEMORY_LIMIT, 64'h1000, 64'd0, 4'd0);
        send_beat(OP_MAP_ENTRY, USABLE_TYPE, LOW_MEMORY_LIMIT + 64'd1, 64'h10, 64'd0, 4'd0);
        send_beat(OP_MAP_ENTRY, USABLE_TYPE, 64'h9_F000, '1, 64'd0, 4'd0);
        send_beat(OP_MAP_ENTRY, USABLE_TYPE, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 64'd0, 4'd0);
        send_beat(OP_RAW_INSERT, 32'd0, LOW_MEMORY_LIMIT + 64'd1, 64'd0, 64'd0, 4'd0);
        send_beat(OP_RAW_INSERT, 32'd0, 64'd0, 64'd0, 64'd0, 4'd0);
        send_beat(OP_MAP_ENTRY, USABLE_TYPE, 64'd0, LOW_MEMORY_LIMIT + 64'd1, 64'd0, 4'd0);
    endtask

    task automatic test_lookup_and_read();
        send_beat(OP_FIND, 32'd0, 64'd0, 64'd0, '1, 4'd0);
        send_beat(OP_FIND, 32'd0, 64'd0, 64'd0, 64'h10_0000_0000, 4'd0);
        send_beat(OP_FIND, 32'd0, 64'd0, 64'd0, LOW_MEMORY_LIMIT + 64'd1, 4'd0);
        send_beat(OP_FIND, 32'd0, 64'd0, 64'd0, 64'd0, 4'd0);
        send_beat(OP_READ, 32'd0, 64'd0, 64'd0, 64'd0, 4'd0);
        send_beat(OP_READ, 32'd0, 64'd0, 64'd0, 64'd0, 4'd6);
        send_beat(OP_READ, 32'd0, 64'd0, 64'd0, 64'd0, 4'd7);
        send_beat(OP_READ, 32'd0, 64'd0, 64'd0, 64'd0, 4'd15);
    endtask

    task automatic test_backpressure();
        wait_replies_drained();
        src_idle = 1'b0;
        dst_idle = 1'b0;
        hold_len = 200;
        repeat (16) send_random_beat();
        wait_replies_drained();
    endtask

    task automatic test_random_traffic();
        int chunk;
        for (chunk = 0; chunk < 10; chunk++) begin
            src_idle = chunk[0];
            dst_idle = chunk[1];
            if (chunk == 5) wait_replies_drained();
            repeat (112) send_random_beat();
        end
    endtask

    initial begin : ready_driver
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = (hold_len != 0) ? hold_len : idle_cycles(dst_idle);
            hold_len = 0;
            @(negedge aclk);
            repeat (stall) begin
                m_ready <= 1'b0;
                @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : reply_check
        region_reply_t seen;
        region_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_status, m_found_index, m_found_start, m_found_length,
                     m_has_next, m_region_total};
            if (region_replies_due.size() == 0) begin
                if (reply_errors < 10) begin
                    $display("unexpected beat: status %0d index %0d start %h length %h",
                             seen.status, seen.index, seen.start, seen.length);
                end
                reply_errors++;
            end else begin
                want = region_replies_due.pop_front();
                if (seen.status !== want.status || seen.index !== want.index ||
                        seen.start !== want.start || seen.length !== want.length ||
                        seen.has_next !== want.has_next || seen.total !== want.total) begin
                    if (reply_errors < 10) begin
                        $display("mismatch: status exp %0d got %0d, index exp %0d got %0d",
                                 want.status, seen.status, want.index, seen.index);
                        $display("  start exp %h got %h, length exp %h got %h",
                                 want.start, seen.start, want.length, seen.length);
                        $display("  next exp %0b got %0b, total exp %0d got %0d",
                                 want.has_next, seen.has_next, want.total, seen.total);
                    end
                    reply_errors++;
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_opcode = OP_MAP_ENTRY;
        s_entry_type = '0;
        s_base_address = '0;
        s_region_size = '0;
        s_lookup_address = '0;
        s_entry_index = '0;
        foreach (region_starts[i]) begin
            region_starts[i] = '0;
            region_lengths[i] = '0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_map_filter();
        test_lookup_and_read();
        test_backpressure();
        test_random_traffic();

        wait_replies_drained();
        repeat (40) @(posedge aclk);
        if (reply_errors == 0 && region_replies_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
rtl/smrt_pkg.sv
rtl/smrt_front.sv
rtl/smrt_queue.sv
rtl/smrt_back.sv
rtl/sorted_memory_region_table.sv
sim/tb_top.sv
